@@ hdl/bfdh_pkg.sv @@
// Shared types and constants for the double-hashing bloom filter.
// Used by the controller, the datapath and the top level.
package bfdh_pkg;

  localparam int unsigned MAX_BITS_DEF   = 65536;
  localparam int unsigned MAX_HASHES_DEF = 16;

  localparam int unsigned HASH_W        = 64;
  localparam int unsigned HALF_W        = 32;
  localparam int unsigned FILTER_BITS_W = 17;
  localparam int unsigned NUM_HASHES_W  = 5;
  localparam int unsigned CFG_DATA_W    = 17;
  localparam int unsigned CFG_ADDR_W    = 2;

  localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RST = FILTER_BITS_W'(65536);
  localparam logic [NUM_HASHES_W-1:0]  NUM_HASHES_RST  = NUM_HASHES_W'(4);

  // Remainder unit: dividends up to 2^64 (65 bits), a few bits per cycle
  localparam int unsigned DIV_STEP_BITS = 4;
  localparam int unsigned DIV_NBITS     =
    ((HASH_W + 1 + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
  localparam int unsigned DIV_CYCLES    = DIV_NBITS / DIV_STEP_BITS;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FILTER_BITS = 2'd0,
    REG_NUM_HASHES  = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PROBE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic probe_init;
    logic probe_step;
    logic clear_step;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic probe_done;
    logic miss;
    logic clear_done;
  } dp_sts_t;

endpackage

@@ hdl/bloom_filter_double_hash_top.sv @@
// Top level of the double-hashing bloom filter: controller plus datapath.
// Depends on bfdh_pkg, bfdh_controller and bfdh_datapath.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------
//   input    | start / busy       | in_func, in_key_hash
//   result   | out_valid (strobe) | out_present, out_was_query
//   config   | cfg_we             | cfg_addr, cfg_wdata
//
// After reset the store is cleared one bit per cycle, with busy high throughout.
// An item first passes the remainder unit (65-bit dividend, 4 bits per cycle),
// then takes one probe per cycle on the single store port; a query ends at its first
// clear bit. Busy stays high until the result strobe, so the next item waits for it.
// Each result is a one-cycle strobe; the receiver cannot stall it.
module bloom_filter_double_hash_top #(
  parameter int unsigned MAX_BITS   = bfdh_pkg::MAX_BITS_DEF,
  parameter int unsigned MAX_HASHES = bfdh_pkg::MAX_HASHES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bfdh_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [bfdh_pkg::HASH_W-1:0]     in_key_hash,
  output logic                            out_valid,
  output logic                            out_present,
  output logic                            out_was_query
);
  import bfdh_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bfdh_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bfdh_datapath #(
    .MAX_BITS   (MAX_BITS),
    .MAX_HASHES (MAX_HASHES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_func       (in_func),
    .in_key_hash   (in_key_hash),
    .cmd           (cmd),
    .sts           (sts),
    .res_present   (out_present),
    .res_was_query (out_was_query)
  );

endmodule

@@ hdl/bfdh_controller.sv @@
// Sequencer for the bloom filter: clearing pass, remainder phase, probes, result.
// Depends on bfdh_pkg for the state, command and status types.
module bfdh_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bfdh_pkg::dp_sts_t sts,
  output bfdh_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import bfdh_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.probe_init = 1'b1;
          state_nxt      = ST_PROBE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_PROBE: begin
        // a miss seen on the last read ends a query early
        if (sts.miss || sts.probe_done) begin
          state_nxt = ST_RESP;
        end else begin
          cmd.probe_step = 1'b1;
        end
      end
      ST_RESP: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/bfdh_datapath.sv @@
// Datapath: config registers, three-lane remainder unit, probe index stepper, bit store.
// Depends on bfdh_pkg for widths, codes and the command/status structs.
module bfdh_datapath #(
  parameter int unsigned MAX_BITS   = bfdh_pkg::MAX_BITS_DEF,
  parameter int unsigned MAX_HASHES = bfdh_pkg::MAX_HASHES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bfdh_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bfdh_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_func,
  input  logic [bfdh_pkg::HASH_W-1:0]      in_key_hash,
  input  bfdh_pkg::dp_cmd_t                cmd,
  output bfdh_pkg::dp_sts_t                sts,
  output logic                             res_present,
  output logic                             res_was_query
);
  import bfdh_pkg::*;

  localparam int unsigned SW  = $clog2(MAX_BITS + 1);
  localparam int unsigned AW  = $clog2(MAX_BITS);
  localparam int unsigned KW  = $clog2(MAX_HASHES + 1);
  localparam int unsigned DCW = $clog2(DIV_CYCLES + 1);

  logic [FILTER_BITS_W-1:0] fb_r;
  logic [NUM_HASHES_W-1:0]  nh_r;
  logic [SW-1:0]            size_eff;
  logic [KW-1:0]            k_eff;

  logic                     func_r;
  logic [HALF_W-1:0]        hi_r;
  logic [HALF_W-1:0]        acc_r;
  logic [DIV_NBITS-1:0]     div_a_r;
  logic [DIV_NBITS-1:0]     div_b_r;
  logic [DIV_NBITS-1:0]     div_c_r;
  logic [SW-1:0]            rem_a_r;   // 2^64 mod size
  logic [SW-1:0]            rem_b_r;   // h2 mod size
  logic [SW-1:0]            rem_c_r;   // h1 mod size
  logic [DCW-1:0]           div_cnt_r;
  logic [KW-1:0]            probe_cnt_r;
  logic [SW-1:0]            idx_r;
  logic [SW-1:0]            idx_nxt;
  logic                     present_r;
  logic                     rd_pend_r;
  logic                     rd_data_r;
  logic [AW-1:0]            clr_addr_r;

  logic                     mem [MAX_BITS];
  logic                     mem_we;
  logic [AW-1:0]            mem_addr;
  logic                     mem_wdata;

  logic [HALF_W:0]          acc_sum;
  logic [SW:0]              t1;
  logic [SW-1:0]            t2;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= FILTER_BITS_RST;
      nh_r <= NUM_HASHES_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FILTER_BITS: fb_r <= cfg_wdata[FILTER_BITS_W-1:0];
        REG_NUM_HASHES:  nh_r <= cfg_wdata[NUM_HASHES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fb_r == '0) begin
      size_eff = SW'(1);
    end else if (32'(fb_r) > 32'(MAX_BITS)) begin
      size_eff = SW'(MAX_BITS);
    end else begin
      size_eff = SW'(fb_r);
    end
    if (32'(nh_r) > 32'(MAX_HASHES)) begin
      k_eff = KW'(MAX_HASHES);
    end else begin
      k_eff = KW'(nh_r);
    end
  end

  // restoring remainder, DIV_STEP_BITS dividend bits per call, MSB first
  function automatic logic [SW-1:0] rem_shift(
    input logic [SW-1:0]            rem,
    input logic [DIV_STEP_BITS-1:0] bits,
    input logic [SW-1:0]            s
  );
    logic [SW:0]   t;
    logic [SW-1:0] r;
    r = rem;
    for (int j = DIV_STEP_BITS - 1; j >= 0; j--) begin
      t = {r, bits[j]};
      if (t >= {1'b0, s}) begin
        t = t - {1'b0, s};
      end
      r = t[SW-1:0];
    end
    return r;
  endfunction

  // next probe index: x(i+1) = x(i) + h2 mod 2^64; a wrap of the high word
  // drops 2^64, so subtract 2^64 mod size
  always_comb begin
    acc_sum = {1'b0, acc_r} + {1'b0, hi_r};
    t1      = {1'b0, idx_r} + {1'b0, rem_b_r};
    if (t1 >= {1'b0, size_eff}) begin
      t1 = t1 - {1'b0, size_eff};
    end
    t2 = t1[SW-1:0];
    if (acc_sum[HALF_W]) begin
      if (t2 >= rem_a_r) begin
        idx_nxt = t2 - rem_a_r;
      end else begin
        idx_nxt = t2 + (size_eff - rem_a_r);
      end
    end else begin
      idx_nxt = t2;
    end
  end

  // item payload and remainder lanes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      hi_r    <= in_key_hash[HASH_W-1:HALF_W];
      div_a_r <= DIV_NBITS'({1'b1, {HASH_W{1'b0}}});
      div_b_r <= DIV_NBITS'({in_key_hash[HASH_W-1:HALF_W], {HALF_W{1'b0}}});
      div_c_r <= DIV_NBITS'(in_key_hash[HALF_W-1:0]);
      rem_a_r <= '0;
      rem_b_r <= '0;
      rem_c_r <= '0;
    end else if (cmd.div_step) begin
      div_a_r <= div_a_r << DIV_STEP_BITS;
      div_b_r <= div_b_r << DIV_STEP_BITS;
      div_c_r <= div_c_r << DIV_STEP_BITS;
      rem_a_r <= rem_shift(rem_a_r, div_a_r[DIV_NBITS-1 -: DIV_STEP_BITS], size_eff);
      rem_b_r <= rem_shift(rem_b_r, div_b_r[DIV_NBITS-1 -: DIV_STEP_BITS], size_eff);
      rem_c_r <= rem_shift(rem_c_r, div_c_r[DIV_NBITS-1 -: DIV_STEP_BITS], size_eff);
    end
    if (cmd.probe_init) begin
      idx_r <= rem_c_r;
      acc_r <= '0;
    end else if (cmd.probe_step) begin
      idx_r <= idx_nxt;
      acc_r <= acc_sum[HALF_W-1:0];
    end
  end

  // counters and query outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r   <= '0;
      probe_cnt_r <= '0;
      clr_addr_r  <= '0;
      rd_pend_r   <= 1'b0;
      present_r   <= 1'b0;
    end else begin
      rd_pend_r <= cmd.probe_step && (func_r == FUNC_QUERY);
      if (cmd.load) begin
        div_cnt_r <= '0;
        present_r <= 1'b1;
      end else begin
        if (cmd.div_step) begin
          div_cnt_r <= div_cnt_r + DCW'(1);
        end
        if (rd_pend_r && !rd_data_r) begin
          present_r <= 1'b0;
        end
      end
      if (cmd.probe_init) begin
        probe_cnt_r <= '0;
      end else if (cmd.probe_step) begin
        probe_cnt_r <= probe_cnt_r + KW'(1);
      end
      if (cmd.clear_step) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // bit store: one write port, one registered read
  assign mem_we    = cmd.clear_step || (cmd.probe_step && (func_r == FUNC_INSERT));
  assign mem_addr  = cmd.clear_step ? clr_addr_r : idx_r[AW-1:0];
  assign mem_wdata = !cmd.clear_step;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[idx_r[AW-1:0]];
  end

  assign sts.div_done   = (div_cnt_r == DCW'(DIV_CYCLES));
  assign sts.probe_done = (probe_cnt_r == k_eff);
  assign sts.miss       = rd_pend_r && !rd_data_r;
  assign sts.clear_done = (clr_addr_r == AW'(MAX_BITS - 1));

  assign res_present   = present_r && (func_r == FUNC_QUERY);
  assign res_was_query = func_r;

endmodule

@@ hdl/bfdh_checker.sv @@
// Port-level checks for the bloom filter top level, attached by bind.
// Depends only on the ports of bloom_filter_double_hash_top.
module bfdh_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_present,
  input logic out_was_query
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_insert_not_present: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_was_query) |-> !out_present)
    else $error("insert acknowledge reports present");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result right after accept");

endmodule

bind bloom_filter_double_hash_top bfdh_checker u_bfdh_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for bloom_filter_double_hash_top: directed and random
// insert/query beats checked against an in-bench bloom filter predictor.
// Depends on bfdh_pkg and the RTL under hdl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bfdh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic present;
    logic was_query;
  } answer_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  start;
  logic                  busy;
  logic                  in_func;
  logic [HASH_W-1:0]     in_key_hash;
  logic                  out_valid;
  logic                  out_present;
  logic                  out_was_query;

  // predictor state
  bit                     filter_mem [MAX_BITS_DEF];
  logic [FILTER_BITS_W-1:0] cur_bits;
  logic [NUM_HASHES_W-1:0]  cur_hashes;

  answer_t        answer_q [$];
  bit [HASH_W-1:0] key_pool [$];
  int unsigned    err_cnt;
  int unsigned    cycle_cnt;

  bloom_filter_double_hash_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_key_hash  (in_key_hash),
    .out_valid    (out_valid),
    .out_present  (out_present),
    .out_was_query(out_was_query)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Applies one key to the predicted store and returns the expected answer.
  function automatic answer_t bloom_apply(func_t op, bit [HASH_W-1:0] hash);
    bit [63:0]   h1;
    bit [63:0]   h2;
    bit [63:0]   modulus;
    bit [63:0]   idx;
    int unsigned nprobe;
    answer_t     ans;
    h1 = hash & 64'h0000_0000_FFFF_FFFF;
    h2 = hash & 64'hFFFF_FFFF_0000_0000;   // high half stays in place
    if (cur_bits == '0)
      modulus = 64'd1;
    else if (cur_bits > MAX_BITS_DEF)
      modulus = 64'(MAX_BITS_DEF);
    else
      modulus = 64'(cur_bits);
    nprobe = (cur_hashes > MAX_HASHES_DEF) ? MAX_HASHES_DEF : cur_hashes;
    ans.was_query = (op == FUNC_QUERY);
    ans.present   = (op == FUNC_QUERY);
    for (int unsigned i = 0; i < nprobe; i++) begin
      idx = (h1 + 64'(i) * h2) % modulus;
      if (op == FUNC_INSERT) begin
        filter_mem[idx] = 1'b1;
      end else if (!filter_mem[idx]) begin
        ans.present = 1'b0;
        break;
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        $error("unexpected result beat: present=%0b was_query=%0b", out_present, out_was_query);
        err_cnt++;
      end else begin
        exp_ans = answer_q.pop_front();
        if (out_present !== exp_ans.present) begin
          $error("present mismatch: expected %0b, got %0b", exp_ans.present, out_present);
          err_cnt++;
        end
        if (out_was_query !== exp_ans.was_query) begin
          $error("was_query mismatch: expected %0b, got %0b", exp_ans.was_query,
                 out_was_query);
          err_cnt++;
        end
      end
    end
  end

  // Start stays high on return; the next negedge either lowers it or loads a new beat.
  task automatic send_key(func_t op, bit [HASH_W-1:0] hash);
    @(negedge clk);
    start       = 1'b1;
    in_func     = op;
    in_key_hash = hash;
    do @(posedge clk); while (busy);
    answer_q.push_back(bloom_apply(op, hash));
    if (op == FUNC_INSERT) begin
      key_pool.push_back(hash);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end
  endtask

  task automatic wait_all_done();
    @(negedge clk);
    start = 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (addr)
      REG_FILTER_BITS: cur_bits = data[FILTER_BITS_W-1:0];
      REG_NUM_HASHES:  cur_hashes = data[NUM_HASHES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic random_gap(bit quiet);
    if (!quiet && $urandom_range(0, 99) < 28) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  function automatic bit [HASH_W-1:0] rand_hash();
    return {$urandom, $urandom};
  endfunction

  task automatic test_default_config();
    send_key(FUNC_INSERT, 64'h0);
    send_key(FUNC_QUERY, 64'h0);
    send_key(FUNC_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_key(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_key(FUNC_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_key(FUNC_INSERT, 64'h0000_0000_FFFF_FFFF);
    send_key(FUNC_QUERY, 64'hFFFF_FFFF_0000_0000);
  endtask

  // zero size acts as one bit, oversized sizes clamp to the store depth
  task automatic test_size_limits();
    bit [HASH_W-1:0] key;
    key = rand_hash();
    wait_all_done();
    write_reg(REG_FILTER_BITS, '0);
    send_key(FUNC_INSERT, key);
    send_key(FUNC_QUERY, rand_hash());
    wait_all_done();
    write_reg(REG_FILTER_BITS, '1);
    send_key(FUNC_QUERY, key);
    send_key(FUNC_INSERT, key);
    send_key(FUNC_QUERY, key);
  endtask

  task automatic test_probe_limits();
    bit [HASH_W-1:0] key;
    key = rand_hash();
    wait_all_done();
    write_reg(REG_FILTER_BITS, CFG_DATA_W'(MAX_BITS_DEF));
    write_reg(REG_NUM_HASHES, '0);
    send_key(FUNC_QUERY, rand_hash());   // no probes: always present
    send_key(FUNC_INSERT, key);
    wait_all_done();
    write_reg(REG_NUM_HASHES, CFG_DATA_W'(5'h1F));
    send_key(FUNC_QUERY, key);
    send_key(FUNC_INSERT, key);
    wait_all_done();
    write_reg(REG_NUM_HASHES, CFG_DATA_W'(MAX_HASHES_DEF));
    send_key(FUNC_QUERY, key);
  endtask

  task automatic test_spare_regs();
    wait_all_done();
    write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
    send_key(FUNC_QUERY, key_pool[$]);
  endtask

  // shrinking the size keeps the upper bits; growing it back makes them visible again
  task automatic test_size_change();
    bit [HASH_W-1:0] key;
    key = rand_hash();
    wait_all_done();
    write_reg(REG_FILTER_BITS, CFG_DATA_W'(50000));
    write_reg(REG_NUM_HASHES, CFG_DATA_W'(3));
    send_key(FUNC_INSERT, key);
    wait_all_done();
    write_reg(REG_FILTER_BITS, CFG_DATA_W'(16));
    send_key(FUNC_QUERY, key);
    wait_all_done();
    write_reg(REG_FILTER_BITS, CFG_DATA_W'(50000));
    send_key(FUNC_QUERY, key);
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] data;
    bit                    quiet;
    for (int phase = 0; phase < 10; phase++) begin
      wait_all_done();
      case ($urandom_range(0, 9))
        0:       data = '0;
        1:       data = CFG_DATA_W'(MAX_BITS_DEF);
        2:       data = CFG_DATA_W'($urandom_range(MAX_BITS_DEF + 1, 131071));
        3, 4, 5: data = CFG_DATA_W'($urandom_range(1, 64));
        6, 7:    data = CFG_DATA_W'($urandom_range(65, 2048));
        default: data = CFG_DATA_W'($urandom_range(2049, MAX_BITS_DEF - 1));
      endcase
      write_reg(REG_FILTER_BITS, data);
      data = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 7))
        0:       data[NUM_HASHES_W-1:0] = '0;
        1:       data[NUM_HASHES_W-1:0] = NUM_HASHES_W'($urandom_range(17, 31));
        2:       data[NUM_HASHES_W-1:0] = NUM_HASHES_W'(MAX_HASHES_DEF);
        default: data[NUM_HASHES_W-1:0] = NUM_HASHES_W'($urandom_range(1, 15));
      endcase
      write_reg(REG_NUM_HASHES, data);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
      quiet = (phase == 4);   // one phase runs back to back
      for (int n = 0; n < 100; n++) begin
        random_gap(quiet);
        if ($urandom_range(0, 1))
          send_key(FUNC_INSERT, rand_hash());
        else if ($urandom_range(0, 1) && key_pool.size() != 0)
          send_key(FUNC_QUERY, key_pool[$urandom_range(0, key_pool.size() - 1)]);
        else
          send_key(FUNC_QUERY, rand_hash());
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    start       = 1'b0;
    in_func     = 1'b0;
    in_key_hash = '0;
    cur_bits    = FILTER_BITS_RST;
    cur_hashes  = NUM_HASHES_RST;
    err_cnt     = 0;
    cycle_cnt   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);   // store clearing pass

    test_default_config();
    test_size_limits();
    test_probe_limits();
    test_spare_regs();
    test_size_change();
    test_random_traffic();

    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answer_q.size() != 0) begin
      $error("%0d expected result beats never arrived", answer_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
